// ===== design/ffpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared widths, codes and types for the first-fit pool allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    localparam int ADDR_W     = 12;
    localparam int BYTES_W    = 13;
    localparam int STATUS_W   = 2;
    localparam int REC_DEPTH  = 256;
    localparam int REC_IW     = 8;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NULL_FREE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LIST_FULL = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0]  off;
        logic [BYTES_W-1:0] bytes;
    } fl_entry_t;

endpackage

// ===== design/ffpa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_div
// Division by a power-of-two constant; quotient and remainder registered,
// valid in the cycle after start.
// ----------------------------------------------------------------------------
module ffpa_div #(
    parameter int DIVISOR = 16,
    parameter int W       = ffpa_pkg::BYTES_W
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [W-1:0]                 dividend,
    output logic                         done,
    output logic [W-1:0]                 quot,
    output logic [$clog2(DIVISOR)-1:0]   rem
);

    localparam int RMW = $clog2(DIVISOR);

    logic [RMW-1:0] rem_reg, rem_next;
    logic [W-1:0]   quo_reg, quo_next;
    logic           done_reg, done_next;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        done_next = start;
        if (start)
        begin
            rem_next = dividend[RMW-1:0];
            quo_next = dividend >> RMW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

// ===== design/first_fit_pool_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_pool_allocator_top
// First-fit free-list allocator with bump pointer over a fixed pool.
// The search and the compaction each read the free-list memory one entry per cycle.
// Throughput: one item at a time; ready only between items.
// Reset: control, count and bump pointer cleared; memories left unwritten.
// ----------------------------------------------------------------------------
module first_fit_pool_allocator_top #(
    parameter int POOL_BYTES      = 4096,
    parameter int ALIGN_BYTES     = 16,
    parameter int HEADER_BYTES    = 16,
    parameter int FREE_LIST_DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  logic                             mode,
    input  logic [ffpa_pkg::ADDR_W-1:0]      request_size,
    input  logic [ffpa_pkg::ADDR_W-1:0]      free_address,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output logic [ffpa_pkg::ADDR_W-1:0]      result_address,
    output logic [ffpa_pkg::STATUS_W-1:0]    status,
    output logic                             from_free_list
);

    localparam int AW    = ffpa_pkg::ADDR_W;
    localparam int BW    = ffpa_pkg::BYTES_W;
    localparam int SW    = ffpa_pkg::STATUS_W;
    localparam int IW    = (FREE_LIST_DEPTH > 1) ? $clog2(FREE_LIST_DEPTH) : 1;
    localparam int CW    = $clog2(FREE_LIST_DEPTH + 1);
    localparam int REM_W = $clog2(ALIGN_BYTES);
    localparam int CMP_W = ($clog2(POOL_BYTES) > BW) ? $clog2(POOL_BYTES) + 1 : BW + 1;

    localparam logic [BW-1:0] ROUND_ADD = BW'(HEADER_BYTES + ALIGN_BYTES - 1);
    localparam logic [AW-1:0] HDR       = AW'(HEADER_BYTES);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_NDIV  = 8'b0000_0010,
        S_SRCH  = 8'b0000_0100,
        S_SHIFT = 8'b0000_1000,
        S_BDIV  = 8'b0001_0000,
        S_FDIV  = 8'b0010_0000,
        S_FREC  = 8'b0100_0000,
        S_RESP  = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [BW-1:0]    need_reg, need_next;
    logic [AW-1:0]    blk_reg, blk_next;
    logic [BW-1:0]    bump_reg, bump_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    scan_reg, scan_next;
    logic [CW-1:0]    pidx_reg, pidx_next;
    logic [CW-1:0]    j_reg, j_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    res_addr_reg, res_addr_next;
    logic [SW-1:0]    res_status_reg, res_status_next;
    logic             res_reuse_reg, res_reuse_next;
    logic             out_valid_reg, out_valid_next;
    logic [AW-1:0]    out_addr_reg, out_addr_next;
    logic [SW-1:0]    out_status_reg, out_status_next;
    logic             out_reuse_reg, out_reuse_next;

    ffpa_pkg::fl_entry_t fl_mem [FREE_LIST_DEPTH];
    ffpa_pkg::fl_entry_t fl_rd_data_reg;
    ffpa_pkg::fl_entry_t fl_wr_data;
    logic                fl_rd_en, fl_wr_en;
    logic [IW-1:0]       fl_rd_addr, fl_wr_addr;

    logic [BW-1:0]                 rec_mem [ffpa_pkg::REC_DEPTH];
    logic [BW-1:0]                 rec_rd_data_reg;
    logic                          rec_rd_en, rec_wr_en;
    logic [ffpa_pkg::REC_IW-1:0]   rec_addr;

    logic              div_start;
    logic [BW-1:0]     div_dividend;
    logic              div_done;
    logic [BW-1:0]     div_quot;
    logic [REM_W-1:0]  div_rem;

    logic              hit;
    logic [CW-1:0]     jn;
    logic [CMP_W-1:0]  bump_sum;

    ffpa_div #(
        .DIVISOR (ALIGN_BYTES),
        .W       (BW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    always_comb
    begin
        state_next      = state_reg;
        need_next       = need_reg;
        blk_next        = blk_reg;
        bump_next       = bump_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        pidx_next       = pidx_reg;
        j_next          = j_reg;
        pend_next       = pend_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        res_reuse_next  = res_reuse_reg;
        out_valid_next  = out_valid_reg & ~rsp_ready;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        out_reuse_next  = out_reuse_reg;

        fl_rd_en     = 1'b0;
        fl_rd_addr   = '0;
        fl_wr_en     = 1'b0;
        fl_wr_addr   = '0;
        fl_wr_data   = fl_rd_data_reg;
        rec_rd_en    = 1'b0;
        rec_wr_en    = 1'b0;
        rec_addr     = div_quot[ffpa_pkg::REC_IW-1:0];
        div_start    = 1'b0;
        div_dividend = '0;

        req_ready = (state_reg == S_IDLE);
        hit       = pend_reg && (fl_rd_data_reg.bytes >= need_reg);
        jn        = j_reg + CW'(1);
        bump_sum  = CMP_W'(bump_reg) + CMP_W'(need_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_addr_next   = '0;
                    res_status_next = ffpa_pkg::ST_DONE;
                    res_reuse_next  = 1'b0;
                    if (mode == ffpa_pkg::MODE_ALLOC)
                    begin
                        div_dividend = BW'(request_size) + ROUND_ADD;
                        div_start    = 1'b1;
                        need_next    = div_dividend;
                        state_next   = S_NDIV;
                    end
                    else if (free_address == '0)
                    begin
                        res_status_next = ffpa_pkg::ST_NULL_FREE;
                        state_next      = S_RESP;
                    end
                    else if (count_reg >= CW'(FREE_LIST_DEPTH))
                    begin
                        res_status_next = ffpa_pkg::ST_LIST_FULL;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        blk_next     = free_address - HDR;
                        div_dividend = BW'(blk_next);
                        div_start    = 1'b1;
                        state_next   = S_FDIV;
                    end
                end
            end

            S_NDIV:
            begin
                if (div_done)
                begin
                    need_next  = need_reg - BW'(div_rem);
                    scan_next  = '0;
                    pend_next  = 1'b0;
                    state_next = S_SRCH;
                end
            end

            S_SRCH:
            begin
                if (hit)
                begin
                    res_addr_next  = fl_rd_data_reg.off + HDR;
                    res_reuse_next = 1'b1;
                    j_next         = pidx_reg;
                    pend_next      = 1'b0;
                    state_next     = S_SHIFT;
                end
                else if (scan_reg < count_reg)
                begin
                    fl_rd_en   = 1'b1;
                    fl_rd_addr = scan_reg[IW-1:0];
                    pend_next  = 1'b1;
                    pidx_next  = scan_reg;
                    scan_next  = scan_reg + CW'(1);
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else if (bump_sum < CMP_W'(POOL_BYTES))
                begin
                    div_dividend = BW'(bump_reg[AW-1:0]);
                    div_start    = 1'b1;
                    state_next   = S_BDIV;
                end
                else
                begin
                    res_status_next = ffpa_pkg::ST_OOM;
                    state_next      = S_RESP;
                end
            end

            S_SHIFT:
            begin
                // compaction: read entry j+1, write it one slot down in the next cycle
                if (pend_reg)
                begin
                    fl_wr_en   = 1'b1;
                    fl_wr_addr = IW'(pidx_reg - CW'(1));
                    fl_wr_data = fl_rd_data_reg;
                end
                if (jn < count_reg)
                begin
                    fl_rd_en   = 1'b1;
                    fl_rd_addr = jn[IW-1:0];
                    pend_next  = 1'b1;
                    pidx_next  = jn;
                    j_next     = jn;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_RESP;
                end
            end

            S_BDIV:
            begin
                if (div_done)
                begin
                    rec_wr_en     = 1'b1;
                    res_addr_next = bump_reg[AW-1:0] + HDR;
                    bump_next     = bump_reg + need_reg;
                    state_next    = S_RESP;
                end
            end

            S_FDIV:
            begin
                if (div_done)
                begin
                    rec_rd_en  = 1'b1;
                    state_next = S_FREC;
                end
            end

            S_FREC:
            begin
                fl_wr_en         = 1'b1;
                fl_wr_addr       = count_reg[IW-1:0];
                fl_wr_data.off   = blk_reg;
                fl_wr_data.bytes = rec_rd_data_reg;
                count_next       = count_reg + CW'(1);
                state_next       = S_RESP;
            end

            S_RESP:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = res_addr_reg;
                    out_status_next = res_status_reg;
                    out_reuse_next  = res_reuse_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bump_reg      <= '0;
            count_reg     <= '0;
            scan_reg      <= '0;
            pidx_reg      <= '0;
            j_reg         <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bump_reg      <= bump_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            pidx_reg      <= pidx_next;
            j_reg         <= j_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg       <= need_next;
        blk_reg        <= blk_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        res_reuse_reg  <= res_reuse_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
        out_reuse_reg  <= out_reuse_next;
    end

    always_ff @(posedge clk)
    begin
        if (fl_wr_en)
        begin
            fl_mem[fl_wr_addr] <= fl_wr_data;
        end
        if (fl_rd_en)
        begin
            fl_rd_data_reg <= fl_mem[fl_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_wr_en)
        begin
            rec_mem[rec_addr] <= need_reg;
        end
        if (rec_rd_en)
        begin
            rec_rd_data_reg <= rec_mem[rec_addr];
        end
    end

    assign rsp_valid      = out_valid_reg;
    assign result_address = out_addr_reg;
    assign status         = out_status_reg;
    assign from_free_list = out_reuse_reg;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit pool allocator. Drives alloc and free
// requests over valid/ready, predicts every response beat from its own model
// of the bump pointer, free list and block size records, and compares each
// response field by field. A directed opener is followed by random traffic
// under three idling profiles on the request and response sides.
// ----------------------------------------------------------------------------
module testbench;

    localparam int POOL_BYTES   = 4096;
    localparam int ALIGN_BYTES  = 16;
    localparam int HEADER_BYTES = 16;
    localparam int LIST_DEPTH   = 16;
    localparam int RANDOM_OPS   = 830;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 60;

    typedef struct {
        logic [ffpa_pkg::ADDR_W-1:0]   addr;
        logic [ffpa_pkg::STATUS_W-1:0] status;
        logic                          reused;
    } grant_t;

    class pool_scoreboard;
        logic [ffpa_pkg::BYTES_W-1:0] bump;
        logic [ffpa_pkg::ADDR_W-1:0]  list_off [LIST_DEPTH];
        logic [ffpa_pkg::BYTES_W-1:0] list_bytes [LIST_DEPTH];
        int                           list_count;
        logic [ffpa_pkg::BYTES_W-1:0] size_rec [ffpa_pkg::REC_DEPTH];
        bit                           rec_valid [ffpa_pkg::REC_DEPTH];
        grant_t                       grant_queue [$];
        grant_t                       last_grant;
        int                           failures;

        function new();
            bump       = '0;
            list_count = 0;
            failures   = 0;
            foreach (rec_valid[k])
                rec_valid[k] = 1'b0;
        endfunction

        function int rec_index(logic [ffpa_pkg::ADDR_W-1:0] blk);
            return (blk / ALIGN_BYTES) % ffpa_pkg::REC_DEPTH;
        endfunction

        function bit block_recorded(logic [ffpa_pkg::ADDR_W-1:0] fa);
            logic [ffpa_pkg::ADDR_W-1:0] blk;
            blk = ffpa_pkg::ADDR_W'(fa - HEADER_BYTES);
            return rec_valid[rec_index(blk)];
        endfunction

        // one accepted request beat -> expected response
        function void predict_grant(logic m, logic [ffpa_pkg::ADDR_W-1:0] sz,
                                    logic [ffpa_pkg::ADDR_W-1:0] fa);
            grant_t                      g;
            int unsigned                 need;
            logic [ffpa_pkg::ADDR_W-1:0] blk;
            int                          hit;
            int                          i;
            g.addr   = '0;
            g.status = ffpa_pkg::ST_DONE;
            g.reused = 1'b0;
            if (m == ffpa_pkg::MODE_ALLOC)
            begin
                need = (sz + HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
                hit  = -1;
                for (i = 0; i < list_count && hit < 0; i++)
                    if (list_bytes[i] >= need)
                        hit = i;
                if (hit >= 0)
                begin
                    g.addr = ffpa_pkg::ADDR_W'(list_off[hit] + HEADER_BYTES);
                    for (i = hit; i + 1 < list_count; i++)
                    begin
                        list_off[i]   = list_off[i + 1];
                        list_bytes[i] = list_bytes[i + 1];
                    end
                    list_count--;
                    g.reused = 1'b1;
                end
                else if (bump + need < POOL_BYTES)
                begin
                    blk                       = ffpa_pkg::ADDR_W'(bump);
                    size_rec[rec_index(blk)]  = ffpa_pkg::BYTES_W'(need);
                    rec_valid[rec_index(blk)] = 1'b1;
                    bump                      = ffpa_pkg::BYTES_W'(bump + need);
                    g.addr                    = ffpa_pkg::ADDR_W'(blk + HEADER_BYTES);
                end
                else
                    g.status = ffpa_pkg::ST_OOM;
            end
            else if (fa == '0)
                g.status = ffpa_pkg::ST_NULL_FREE;
            else if (list_count >= LIST_DEPTH)
                g.status = ffpa_pkg::ST_LIST_FULL;
            else
            begin
                blk                    = ffpa_pkg::ADDR_W'(fa - HEADER_BYTES);
                list_off[list_count]   = blk;
                list_bytes[list_count] = size_rec[rec_index(blk)];
                list_count++;
            end
            grant_queue.push_back(g);
            last_grant = g;
        endfunction

        function void report(string what, int unsigned exp_v, int unsigned got_v);
            failures++;
            $display("%0t: %s expected %0d, got %0d", $time, what, exp_v, got_v);
        endfunction

        function void check_grant(logic [ffpa_pkg::ADDR_W-1:0] addr,
                                  logic [ffpa_pkg::STATUS_W-1:0] st,
                                  logic reused);
            grant_t exp_g;
            if (grant_queue.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected response beat addr=%0d status=%0d reused=%0d",
                         $time, addr, st, reused);
                return;
            end
            exp_g = grant_queue.pop_front();
            if (addr !== exp_g.addr)
                report("result_address", 32'(exp_g.addr), 32'(addr));
            if (st !== exp_g.status)
                report("status", 32'(exp_g.status), 32'(st));
            if (reused !== exp_g.reused)
                report("from_free_list", 32'(exp_g.reused), 32'(reused));
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          req_valid;
    logic                          req_ready;
    logic                          mode;
    logic [ffpa_pkg::ADDR_W-1:0]   request_size;
    logic [ffpa_pkg::ADDR_W-1:0]   free_address;
    logic                          rsp_valid;
    logic                          rsp_ready;
    logic [ffpa_pkg::ADDR_W-1:0]   result_address;
    logic [ffpa_pkg::STATUS_W-1:0] status;
    logic                          from_free_list;

    pool_scoreboard                sb = new();
    logic [ffpa_pkg::ADDR_W-1:0]   live_addrs [$];
    int                            send_idle_pct;
    int                            take_idle_pct;
    int                            cycle_count;

    first_fit_pool_allocator_top #(
        .POOL_BYTES      (POOL_BYTES),
        .ALIGN_BYTES     (ALIGN_BYTES),
        .HEADER_BYTES    (HEADER_BYTES),
        .FREE_LIST_DEPTH (LIST_DEPTH)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .mode           (mode),
        .request_size   (request_size),
        .free_address   (free_address),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .result_address (result_address),
        .status         (status),
        .from_free_list (from_free_list)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(negedge clk)
        rsp_ready <= ($urandom_range(99) >= take_idle_pct);

    always @(posedge clk)
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_grant(result_address, status, from_free_list);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_op(input logic m, input logic [ffpa_pkg::ADDR_W-1:0] sz,
                           input logic [ffpa_pkg::ADDR_W-1:0] fa);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid    <= 1'b1;
        mode         <= m;
        request_size <= sz;
        free_address <= fa;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.predict_grant(m, sz, fa);
    endtask

    task automatic send_alloc(input logic [ffpa_pkg::ADDR_W-1:0] sz);
        send_op(ffpa_pkg::MODE_ALLOC, sz, ffpa_pkg::ADDR_W'($urandom_range(0, 4095)));
        if (sb.last_grant.status == ffpa_pkg::ST_DONE)
            live_addrs.push_back(sb.last_grant.addr);
    endtask

    task automatic send_free(input logic [ffpa_pkg::ADDR_W-1:0] fa);
        send_op(ffpa_pkg::MODE_FREE, ffpa_pkg::ADDR_W'($urandom_range(0, 4095)), fa);
    endtask

    // drop valid, then hold off until every response beat is back
    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.grant_queue.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [ffpa_pkg::ADDR_W-1:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return ffpa_pkg::ADDR_W'($urandom_range(0, 95));
        if (r < 95)
            return ffpa_pkg::ADDR_W'($urandom_range(96, 511));
        return ffpa_pkg::ADDR_W'($urandom_range(512, 4095));
    endfunction

    // only blocks whose size has been recorded are ever freed
    function automatic logic [ffpa_pkg::ADDR_W-1:0] pick_free_addr();
        int                          r;
        int                          k;
        int                          tries;
        logic [ffpa_pkg::ADDR_W-1:0] fa;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        if (r < 78 && live_addrs.size() > 0)
        begin
            k  = $urandom_range(0, live_addrs.size() - 1);
            fa = live_addrs[k];
            live_addrs.delete(k);
            return fa;
        end
        for (tries = 0; tries < 32; tries++)
        begin
            fa = ffpa_pkg::ADDR_W'(($urandom_range(0, ffpa_pkg::REC_DEPTH - 2) + 1)
                                   * ALIGN_BYTES + $urandom_range(0, ALIGN_BYTES - 1));
            if (sb.block_recorded(fa))
                return fa;
        end
        return '0;
    endfunction

    initial
    begin
        logic [ffpa_pkg::ADDR_W-1:0] addr_small;
        logic [ffpa_pkg::ADDR_W-1:0] addr_one;
        logic [ffpa_pkg::ADDR_W-1:0] addr_mid;
        int                          n;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        mode          = ffpa_pkg::MODE_ALLOC;
        request_size  = '0;
        free_address  = '0;
        rsp_ready     = 1'b0;
        cycle_count   = 0;
        send_idle_pct = 36;
        take_idle_pct = 88;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_free('0);
        send_alloc(12'd0);
        addr_small = sb.last_grant.addr;
        send_alloc(12'd4095);
        send_alloc(12'd1);
        addr_one = sb.last_grant.addr;
        send_alloc(12'd17);
        addr_mid = sb.last_grant.addr;
        send_free(addr_mid);
        send_free(addr_small);
        // oldest listed block is the larger one and is taken whole
        send_alloc(12'd0);
        send_alloc(12'd200);
        // block would end exactly at the pool limit
        send_alloc(ffpa_pkg::ADDR_W'(POOL_BYTES - HEADER_BYTES - sb.bump));
        send_free(ffpa_pkg::ADDR_W'(addr_one + 5));
        send_free(ffpa_pkg::ADDR_W'(addr_one + 5));
        repeat (14) send_free(addr_one);

        for (n = 0; n < RANDOM_OPS; n++)
        begin
            if (n == RANDOM_OPS / 3)
            begin
                wait_drained();
                send_idle_pct = 88;
                take_idle_pct = 36;
            end
            if (n == 2 * RANDOM_OPS / 3)
            begin
                wait_drained();
                send_idle_pct = 0;
                take_idle_pct = 0;
            end
            if ($urandom_range(99) < 55)
                send_alloc(pick_size());
            else
                send_free(pick_free_addr());
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.grant_queue.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
